// ===== hw/rtl/moesi_pkg.sv =====
// Shared types, codes and the MOESI transition function for the line controller.
package moesi_pkg;

  localparam int unsigned LINES_DEFAULT = 1024;
  localparam int unsigned IDX_W = 10;

  typedef enum logic [3:0] {
    ST_I   = 4'd0,
    ST_S   = 4'd1,
    ST_E   = 4'd2,
    ST_O   = 4'd3,
    ST_M   = 4'd4,
    ST_IM  = 4'd5,
    ST_ISE = 4'd6,
    ST_OM  = 4'd7,
    ST_SM  = 4'd8
  } line_state_e;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_GETS  = 3'd2,
    OP_GETM  = 3'd3,
    OP_DATA  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_GETS = 2'd1,
    REQ_GETM = 2'd2
  } bus_req_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] line_index;
    logic [31:0]      address;
    logic [3:0]       requester;
    logic             shared_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  bus_request;
    logic        data_to_processor;
    logic        data_on_bus;
    logic [3:0]  data_destination;
    logic        assert_shared;
    logic [31:0] message_address;
    logic [3:0]  next_state;
    logic        illegal_message;
    logic [31:0] miss_total;
    logic [31:0] upgrade_total;
  } out_item_t;

  typedef struct packed {
    logic [3:0] nx;
    logic [1:0] bus;
    logic       to_proc;
    logic       on_bus;
    logic       share;
    logic       bad;
    logic       miss;
    logic       upgrade;
  } step_t;

  // One protocol step for a line that is in range.
  function automatic step_t coh_step(logic [2:0] op, logic [3:0] st, logic shared);
    step_t r;
    logic  store;
    logic  gets;
    logic  getm;
    r     = '0;
    r.nx  = st;
    store = (op == OP_STORE);
    gets  = (op == OP_GETS);
    getm  = (op == OP_GETM);
    if (op == OP_LOAD || op == OP_STORE) begin
      case (st)
        ST_I: begin
          r.bus  = store ? REQ_GETM : REQ_GETS;
          r.nx   = store ? ST_IM : ST_ISE;
          r.miss = 1'b1;
        end
        ST_S: begin
          if (store) begin
            r.bus  = REQ_GETM;
            r.nx   = ST_SM;
            r.miss = 1'b1;
          end else begin
            r.share   = 1'b1;
            r.to_proc = 1'b1;
          end
        end
        ST_E: begin
          r.to_proc = 1'b1;
          if (store) begin
            r.nx      = ST_M;
            r.upgrade = 1'b1;
          end
        end
        ST_O: begin
          if (store) begin
            r.bus  = REQ_GETM;
            r.nx   = ST_OM;
            r.miss = 1'b1;
          end else begin
            r.to_proc = 1'b1;
          end
        end
        ST_M:    r.to_proc = 1'b1;
        default: r.bad = 1'b1;
      endcase
    end else if (op == OP_GETS || op == OP_GETM || op == OP_DATA) begin
      case (st)
        ST_I: ;
        ST_S: begin
          if (gets) r.share = 1'b1;
          else if (getm) r.nx = ST_I;
          else r.bad = 1'b1;
        end
        ST_E, ST_O, ST_M: begin
          if (gets) begin
            r.on_bus = 1'b1;
            r.share  = 1'b1;
            if (st == ST_E) r.nx = ST_S;
            else if (st == ST_M) r.nx = ST_O;
          end else if (getm) begin
            r.on_bus = 1'b1;
            r.nx     = ST_I;
          end else begin
            r.bad = 1'b1;
          end
        end
        ST_IM: begin
          if (!gets && !getm) begin
            r.to_proc = 1'b1;
            r.nx      = ST_M;
          end
        end
        ST_ISE: begin
          if (!gets && !getm) begin
            r.to_proc = 1'b1;
            r.nx      = shared ? ST_S : ST_E;
          end
        end
        ST_OM: begin
          if (gets) begin
            r.on_bus = 1'b1;
            r.share  = 1'b1;
          end else if (getm) begin
            r.on_bus = 1'b1;
            r.nx     = ST_IM;
          end else begin
            r.to_proc = 1'b1;
            r.nx      = ST_M;
          end
        end
        ST_SM: begin
          if (gets) r.share = 1'b1;
          else if (getm) r.nx = ST_IM;
          else begin
            r.to_proc = 1'b1;
            r.nx      = ST_M;
          end
        end
        default: r.bad = 1'b1;
      endcase
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/moesi_state_ram.sv =====
// Line state memory with a registered read and a clearing sweep after reset.
module moesi_state_ram import moesi_pkg::*; #(
  parameter int unsigned LINES = LINES_DEFAULT,
  parameter int unsigned AW    = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [3:0]    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [3:0]    wr_data_i,
  output logic          busy_o
);

  logic [3:0]    mem [LINES];
  logic [3:0]    rd_data_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] clr_d;
  logic          busy_q;
  logic          busy_d;
  logic          we;
  logic [AW-1:0] waddr;
  logic [3:0]    wdata;

  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(LINES - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  // The sweep owns the write port until every line holds Invalid.
  assign we    = busy_q | wr_en_i;
  assign waddr = busy_q ? clr_q : wr_addr_i;
  assign wdata = busy_q ? ST_I : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

// ===== hw/rtl/moesi_coherence_line_controller.sv =====
// Top level of the MOESI snooping coherence line controller.
//
//  Channel  Direction  Handshake                Payload
//  in       input      in_valid_i / in_stall_o  in_data_i  (in_item_t)
//  out      output     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// One item is taken per cycle when the output side keeps up; each result passes
// through the state memory read register and then the protocol step into the
// output register.
// After reset the state memory is swept to Invalid, one line per cycle, so the
// input stalls until the sweep has cleared every line.
// A stalled output holds the item in the step stage, which then stalls the input.
module moesi_coherence_line_controller import moesi_pkg::*; #(
  parameter int unsigned LINES = LINES_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned IW = AW + IDX_W;

  // Incoming index, widened so that the range check works for any LINES.
  logic [IW-1:0] in_idx_wide;
  logic          in_fire;
  logic          ram_busy;
  logic [3:0]    rd_data;

  // Step stage: the item whose state read is returning this cycle.
  logic          s1_valid_q;
  in_item_t      s1_item_q;
  logic          s1_inrange_q;
  logic          s1_fire;
  logic          s1_wr;
  logic [AW-1:0] s1_addr;

  // Forwarding: set when the line read for the step-stage item was written at
  // the same edge, since the memory then returned the old value.
  logic          fwd_hit_q;
  logic [3:0]    fwd_state_q;

  logic [3:0]    cur_state;
  step_t         step;

  logic [31:0]   miss_cnt_q;
  logic [31:0]   miss_cnt_d;
  logic [31:0]   upg_cnt_q;
  logic [31:0]   upg_cnt_d;

  logic          out_valid_q;
  out_item_t     out_q;
  out_item_t     res;

  assign in_idx_wide = IW'(in_data_i.line_index);

  // The step stage moves on whenever the output register is empty or being taken.
  assign s1_fire    = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = ram_busy | (s1_valid_q & ~s1_fire);
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign s1_addr = AW'(s1_item_q.line_index);
  assign s1_wr   = s1_fire & s1_inrange_q;

  moesi_state_ram #(
    .LINES (LINES),
    .AW    (AW)
  ) u_state_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (in_idx_wide[AW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_wr),
    .wr_addr_i (s1_addr),
    .wr_data_i (step.nx),
    .busy_o    (ram_busy)
  );

  assign cur_state = fwd_hit_q ? fwd_state_q : rd_data;

  // Out-of-range lines are illegal and report Invalid without touching anything.
  always_comb begin
    step = coh_step(s1_item_q.op, cur_state, s1_item_q.shared_in);
    if (!s1_inrange_q) begin
      step     = '0;
      step.bad = 1'b1;
    end
  end

  assign miss_cnt_d = miss_cnt_q + 32'(step.miss);
  assign upg_cnt_d  = upg_cnt_q + 32'(step.upgrade);

  always_comb begin
    res                   = '0;
    res.bus_request       = step.bus;
    res.data_to_processor = step.to_proc;
    res.data_on_bus       = step.on_bus;
    res.data_destination  = step.on_bus ? s1_item_q.requester : 4'd0;
    res.assert_shared     = step.share;
    res.message_address   = ((step.bus != REQ_NONE) || step.to_proc || step.on_bus) ?
                            s1_item_q.address : 32'd0;
    res.next_state        = step.nx;
    res.illegal_message   = step.bad;
    res.miss_total        = miss_cnt_d;
    res.upgrade_total     = upg_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
      miss_cnt_q  <= '0;
      upg_cnt_q   <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= s1_wr && (s1_item_q.line_index == in_data_i.line_index);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
        fwd_hit_q  <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
        miss_cnt_q  <= miss_cnt_d;
        upg_cnt_q   <= upg_cnt_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q    <= in_data_i;
      s1_inrange_q <= (in_idx_wide < IW'(LINES));
      fwd_state_q  <= step.nx;
    end
    if (s1_fire) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // An illegal message never issues anything.
  a_illegal_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.illegal_message |->
      out_q.bus_request == REQ_NONE && !out_q.data_on_bus && !out_q.data_to_processor)
    else $error("illegal message issued a bus or data message");

  // Counters only move when an item leaves the step stage.
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(miss_cnt_q) && $stable(upg_cnt_q))
    else $error("counter changed without a step");

  // No item is accepted while the clearing sweep still owns the memory.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_busy |-> !in_fire && !s1_valid_q)
    else $error("item accepted during the clearing sweep");

  // A forwarded state belongs to an item that is in the step stage.
  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_valid_q)
    else $error("forwarding flag set without a step-stage item");

endmodule
